// ----- rtl/nfc_frame_deframer_defines.svh -----
// Assertion macros shared by the deframer RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef NFC_FRAME_DEFRAMER_DEFINES_SVH
`define NFC_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nfd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nfd next-cycle check failed");

`endif

// ----- rtl/nfd_pkg.sv -----
// Shared types and constants for the frame deframer.
// No dependencies; used by the parser, the output buffer and the top level.
`timescale 1ns / 1ps
package nfd_pkg;

    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd57;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;
    localparam logic [7:0] BYTE_START      = 8'hFF;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_START   = 3'd1,
        ST_LENCHK  = 3'd2,
        ST_DATACHK = 3'd3,
        ST_TOOBIG  = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        t_status     status;
    } t_result;

    // Result handed from the parser to the output buffer.
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_push;

endpackage

// ----- rtl/nfd_if.sv -----
// Valid/ready channel interfaces for received bytes and for results.
// Depends on nothing but the plain handshake signals.
`timescale 1ns / 1ps
interface nfd_in_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] rx_byte;

    modport source (output valid, output frame_start, output rx_byte, input ready);
    modport sink   (input valid, input frame_start, input rx_byte, output ready);
endinterface

interface nfd_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] status;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output status, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_index, input status, output ready);
endinterface

// ----- rtl/nfd_parse.sv -----
// Frame parser: header, length and data checksum checks, payload emission.
// Depends on nfd_pkg and nfc_frame_deframer_defines.svh.
`timescale 1ns / 1ps
`include "nfc_frame_deframer_defines.svh"
module nfd_parse
    import nfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic         i_frame_start,
    input  logic [7:0]   i_rx_byte,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_data,
    output t_result_push o_push
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_LEN,
        S_LCS,
        S_DATA,
        S_DCS
    } t_phase;

    t_phase     r_phase, n_phase, w_phase;
    logic [7:0] r_pos, n_pos, w_pos;
    logic [7:0] r_len, n_len, w_len;
    logic [7:0] r_sum, n_sum, w_sum;
    logic [7:0] r_cnt, n_cnt, w_cnt;
    logic       r_ovf, n_ovf, w_ovf;
    logic [7:0] r_max_payload;
    logic [7:0] w_pos_inc;
    logic [7:0] w_chk;
    t_result_push w_push;

    // A frame start restarts the parser before this byte is examined.
    always_comb begin
        w_phase = i_frame_start ? S_HEAD : r_phase;
        w_pos   = i_frame_start ? 8'd0 : r_pos;
        w_len   = i_frame_start ? 8'd0 : r_len;
        w_sum   = i_frame_start ? 8'd0 : r_sum;
        w_cnt   = i_frame_start ? 8'd0 : r_cnt;
        w_ovf   = i_frame_start ? 1'b0 : r_ovf;
    end

    assign w_pos_inc = w_pos + 8'd1;

    always_comb begin
        n_phase = w_phase;
        n_pos   = w_pos;
        n_len   = w_len;
        n_sum   = w_sum;
        n_cnt   = w_cnt;
        n_ovf   = w_ovf;
        w_chk   = 8'd0;
        w_push.valid             = 1'b0;
        w_push.res.kind          = KIND_STATUS;
        w_push.res.payload_byte  = 8'd0;
        w_push.res.payload_index = w_cnt;
        w_push.res.status        = ST_OK;
        unique case (w_phase)
            S_HEAD: begin
                if (i_rx_byte != ((w_pos == 8'd2) ? BYTE_START : BYTE_ZERO)) begin
                    w_push.valid      = 1'b1;
                    w_push.res.status = ST_START;
                    n_phase           = S_IDLE;
                end else begin
                    n_pos = w_pos_inc;
                    if (w_pos == 8'd2) begin
                        n_phase = S_LEN;
                    end
                end
            end
            S_LEN: begin
                n_len   = i_rx_byte;
                n_phase = S_LCS;
            end
            S_LCS: begin
                w_chk = w_len + i_rx_byte;
                if (w_chk != 8'd0 || w_len == 8'd0) begin
                    w_push.valid      = 1'b1;
                    w_push.res.status = ST_LENCHK;
                    n_phase           = S_IDLE;
                end else begin
                    n_pos   = 8'd0;
                    n_sum   = 8'd0;
                    n_phase = S_DATA;
                end
            end
            S_DATA: begin
                n_sum = w_sum + i_rx_byte;
                // The first data byte is the direction byte and is not payload.
                if (w_pos != 8'd0) begin
                    if (w_cnt < r_max_payload) begin
                        w_push.valid            = 1'b1;
                        w_push.res.kind         = KIND_PAYLOAD;
                        w_push.res.payload_byte = i_rx_byte;
                        n_cnt                   = w_cnt + 8'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_pos = w_pos_inc;
                if (w_pos_inc >= w_len) begin
                    n_phase = S_DCS;
                end
            end
            S_DCS: begin
                w_chk        = w_sum + i_rx_byte;
                w_push.valid = 1'b1;
                n_phase      = S_IDLE;
                if (w_chk != 8'd0) begin
                    w_push.res.status = ST_DATACHK;
                end else if (w_ovf) begin
                    w_push.res.status = ST_TOOBIG;
                end else begin
                    w_push.res.status = ST_OK;
                end
            end
            default: begin
                n_phase = S_IDLE;
            end
        endcase
    end

    assign o_push.valid = w_push.valid & i_accept;
    assign o_push.res   = w_push.res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= S_IDLE;
            r_pos         <= 8'd0;
            r_len         <= 8'd0;
            r_sum         <= 8'd0;
            r_cnt         <= 8'd0;
            r_ovf         <= 1'b0;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_len   <= n_len;
                r_sum   <= n_sum;
                r_cnt   <= n_cnt;
                r_ovf   <= n_ovf;
            end
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

    `NFD_ASSERT_NXT(a_payload_counts, i_clk, i_rst_n,
        o_push.valid && o_push.res.kind == KIND_PAYLOAD, r_cnt == $past(w_cnt) + 8'd1)
    `NFD_ASSERT_NXT(a_status_ends_frame, i_clk, i_rst_n,
        o_push.valid && o_push.res.kind == KIND_STATUS, r_phase == S_IDLE)
    `NFD_ASSERT_NXT(a_idle_ignores, i_clk, i_rst_n,
        i_accept && !i_frame_start && r_phase == S_IDLE, r_phase == S_IDLE)

endmodule

// ----- rtl/nfd_out_buf.sv -----
// Output register with one skid entry for the result channel.
// Depends on nfd_pkg, nfd_if and nfc_frame_deframer_defines.svh.
`timescale 1ns / 1ps
`include "nfc_frame_deframer_defines.svh"
module nfd_out_buf
    import nfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_result_push i_push,
    output logic         o_ready,
    nfd_out_if.source    o_out_ch
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_out_fire;

    assign w_out_fire = r_out_valid & o_out_ch.ready;
    // The skid entry is empty whenever a push may arrive.
    assign o_ready    = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push.valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out       <= i_push.res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_push.res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.result_kind   = r_out.kind;
    assign o_out_ch.payload_byte  = r_out.payload_byte;
    assign o_out_ch.payload_index = r_out.payload_index;
    assign o_out_ch.status        = r_out.status;

    `NFD_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `NFD_ASSERT_NXT(a_skid_moves_up, i_clk, i_rst_n,
        r_skid_valid && w_out_fire, r_out_valid && r_out == $past(r_skid))
    `NFD_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n,
        i_push.valid && r_out_valid && !o_out_ch.ready, r_skid_valid)

endmodule

// ----- rtl/nfc_frame_deframer.sv -----
// A result is registered in the output buffer before it is offered on the output channel.
// Throughput: one received byte per cycle while input ready is high, with at most one result per byte.
// Input ready falls only while two results wait: one on the output, one in the skid entry.
// Reset is synchronous and active low; it clears the parser and restores max_payload to 57.
// Configuration writes are taken at any cycle, but are meant for an idle block.
`timescale 1ns / 1ps
module nfc_frame_deframer
    import nfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    nfd_in_if.sink     i_in_ch,
    nfd_out_if.source  o_out_ch,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    // The parser advances exactly once per input transfer. Its result, if any,
    // is pushed into the output buffer in the same cycle, so only the result register,
    // or the skid entry when the output stalls, lies between input and output.
    t_result_push w_push;
    logic         w_buf_ready;
    logic         w_accept;

    assign i_in_ch.ready = w_buf_ready;
    assign w_accept      = i_in_ch.valid & w_buf_ready;

    nfd_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_frame_start (i_in_ch.frame_start),
        .i_rx_byte     (i_in_ch.rx_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_push        (w_push)
    );

    // The output register decouples the sink: a stalled result moves into the
    // skid entry, and input transfers continue until that entry is occupied.
    nfd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_ready  (w_buf_ready),
        .o_out_ch (o_out_ch)
    );

endmodule
